// ===== sv/dcfe_pkg.sv =====
// shared types, constants and functions of the drive command frame encoder
package dcfe_pkg;

   localparam int CODE_W  = 4;
   localparam int PCT_W   = 7;
   localparam int BYTE_W  = 8;
   localparam int CRC_W   = 16;
   localparam int IDX_W   = 4;
   localparam int SCALE_W = 11;
   localparam int RECIP_W = 16;
   localparam int PROD_W  = SCALE_W + RECIP_W;

   localparam logic [PCT_W-1:0]   PCT_MAX      = 7'd100;
   // full speed is 240 * pct / 100 = 12 * pct / 5, divide by 5 via reciprocal
   localparam logic [RECIP_W-1:0] RECIP_FIVE   = 16'd52429;
   localparam int                 RECIP_SHIFT  = 18;

   localparam logic [BYTE_W-1:0]  FRAME_SYNC   = 8'hFF;
   localparam logic [BYTE_W-1:0]  FRAME_LEN    = 8'h07;
   localparam logic [BYTE_W-1:0]  FRAME_PAD    = 8'h00;
   localparam logic [CRC_W-1:0]   CRC_INIT     = 16'hFFFF;
   localparam logic [CRC_W-1:0]   CRC_POLY     = 16'hA001;

   localparam logic [BYTE_W-1:0]  FLAG_FWD     = 8'hF0;
   localparam logic [BYTE_W-1:0]  FLAG_REV     = 8'hA0;
   localparam logic [BYTE_W-1:0]  FLAG_DIAG    = 8'h50;
   localparam logic [BYTE_W-1:0]  FLAG_SPIN    = 8'hB0;
   localparam logic [BYTE_W-1:0]  FLAG_NONE    = 8'h00;

   // byte positions within the frame
   localparam logic [IDX_W-1:0] IDX_SYNC   = 4'd0;
   localparam logic [IDX_W-1:0] IDX_LEN    = 4'd1;
   localparam logic [IDX_W-1:0] IDX_LEFT   = 4'd2;
   localparam logic [IDX_W-1:0] IDX_PAD_L  = 4'd3;
   localparam logic [IDX_W-1:0] IDX_RIGHT  = 4'd4;
   localparam logic [IDX_W-1:0] IDX_PAD_R  = 4'd5;
   localparam logic [IDX_W-1:0] IDX_FLAG   = 4'd6;
   localparam logic [IDX_W-1:0] IDX_CRC_LO = 4'd7;
   localparam logic [IDX_W-1:0] IDX_CRC_HI = 4'd8;

   typedef enum logic [CODE_W-1:0] {
      DIR_UP         = 4'd0,
      DIR_DOWN       = 4'd1,
      DIR_LEFT       = 4'd2,
      DIR_RIGHT      = 4'd3,
      DIR_LEFT_UP    = 4'd4,
      DIR_RIGHT_UP   = 4'd5,
      DIR_LEFT_DOWN  = 4'd6,
      DIR_RIGHT_DOWN = 4'd7,
      DIR_SPIN       = 4'd8
   } dir_code_type;

   typedef enum logic [1:0] {
      SPD_ZERO = 2'd0,
      SPD_FULL = 2'd1,
      SPD_RED  = 2'd2
   } speed_kind_type;

   typedef struct packed {
      speed_kind_type    left_kind;
      speed_kind_type    right_kind;
      logic [BYTE_W-1:0] flag;
   } dir_entry_type;

   typedef struct packed {
      logic [BYTE_W-1:0] left_speed;
      logic [BYTE_W-1:0] right_speed;
      logic [BYTE_W-1:0] flag;
   } cmd_type;

   function automatic dir_entry_type dir_lookup(input logic [CODE_W-1:0] code);
      dir_entry_type e;
      case (code)
         DIR_UP:         e = '{SPD_FULL, SPD_FULL, FLAG_FWD};
         DIR_DOWN:       e = '{SPD_FULL, SPD_FULL, FLAG_REV};
         DIR_LEFT:       e = '{SPD_ZERO, SPD_FULL, FLAG_FWD};
         DIR_RIGHT:      e = '{SPD_FULL, SPD_ZERO, FLAG_FWD};
         DIR_LEFT_UP:    e = '{SPD_RED,  SPD_FULL, FLAG_DIAG};
         DIR_RIGHT_UP:   e = '{SPD_FULL, SPD_RED,  FLAG_DIAG};
         DIR_LEFT_DOWN:  e = '{SPD_FULL, SPD_FULL, FLAG_NONE};
         DIR_RIGHT_DOWN: e = '{SPD_FULL, SPD_RED,  FLAG_NONE};
         DIR_SPIN:       e = '{SPD_RED,  SPD_FULL, FLAG_SPIN};
         default:        e = '{SPD_ZERO, SPD_ZERO, FLAG_NONE};
      endcase
      return e;
   endfunction

   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_cur,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc_cur ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/drive_command_frame_encoder.sv =====
// drive command frame encoder: input register, speed stage and frame serializer
// path: input register, speed stage register, then the serializer, which sends the nine frame bytes in order
// throughput: one frame byte per cycle while rsp_tready is high, set by the byte-wide output
// a new command is taken while the previous frame is still being sent
// reset: synchronous, active high; clears all valid flags and the byte counter
module drive_command_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // direction_code [3:0], speed_percent [10:4], zero [15:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // frame_byte [7:0]
   output logic        rsp_tlast
);
   import dcfe_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic              speed_ready;
   logic              cmd_valid;
   logic              cmd_ready;
   cmd_type           cmd;

   assign req_tready = !in_valid_ff || speed_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      code_in     = code_ff;
      pct_in      = pct_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         code_in     = req_tdata[CODE_W-1:0];
         pct_in      = req_tdata[CODE_W +: PCT_W];
      end else if (speed_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      code_ff <= code_in;
      pct_ff  <= pct_in;
   end

   dcfe_speed_stage u_speed (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (speed_ready),
      .in_code   (code_ff),
      .in_pct    (pct_ff),
      .out_valid (cmd_valid),
      .out_ready (cmd_ready),
      .out_cmd   (cmd)
   );

   dcfe_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== sv/dcfe_speed_stage.sv =====
// wheel speed and flag stage: table lookup and scaled speed, registered
module dcfe_speed_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dcfe_pkg::CODE_W-1:0] in_code,
   input  logic [dcfe_pkg::PCT_W-1:0]  in_pct,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dcfe_pkg::cmd_type           out_cmd
);
   import dcfe_pkg::*;

   logic                valid_ff, valid_in;
   cmd_type             cmd_ff, cmd_in;
   dir_entry_type       entry;
   logic [PCT_W-1:0]    pct_sat;
   logic [SCALE_W-1:0]  scaled;
   logic [PROD_W-1:0]   prod;
   logic [BYTE_W-1:0]   full_speed;
   logic [BYTE_W-1:0]   red_speed;
   logic                load;

   function automatic logic [BYTE_W-1:0] pick_speed(input speed_kind_type kind,
                                                    input logic [BYTE_W-1:0] full,
                                                    input logic [BYTE_W-1:0] red);
      logic [BYTE_W-1:0] s;
      case (kind)
         SPD_FULL: s = full;
         SPD_RED:  s = red;
         default:  s = '0;
      endcase
      return s;
   endfunction

   assign pct_sat    = (in_pct > PCT_MAX) ? PCT_MAX : in_pct;
   // 12 * pct
   assign scaled     = {1'b0, pct_sat, 3'b000} + {2'b00, pct_sat, 2'b00};
   assign prod       = PROD_W'(scaled) * PROD_W'(RECIP_FIVE);
   assign full_speed = prod[RECIP_SHIFT +: BYTE_W];
   assign red_speed  = {{(BYTE_W-PCT_W){1'b0}}, pct_sat};
   assign entry      = dir_lookup(in_code);

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (load) begin
         valid_in           = 1'b1;
         cmd_in.left_speed  = pick_speed(entry.left_kind, full_speed, red_speed);
         cmd_in.right_speed = pick_speed(entry.right_kind, full_speed, red_speed);
         cmd_in.flag        = entry.flag;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign out_valid = valid_ff;
   assign out_cmd   = cmd_ff;

endmodule

// ===== sv/dcfe_serializer.sv =====
// frame serializer: sends nine bytes per command and folds bytes 1 to 6 into the crc
module dcfe_serializer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  dcfe_pkg::cmd_type           cmd,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [dcfe_pkg::BYTE_W-1:0] out_byte,
   output logic                        out_last
);
   import dcfe_pkg::*;

   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   index_ff, index_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [BYTE_W-1:0]  cur_byte;
   logic               take;
   logic               is_last;
   logic               in_crc_span;
   logic               load;

   always_comb begin
      case (index_ff)
         IDX_SYNC:   cur_byte = FRAME_SYNC;
         IDX_LEN:    cur_byte = FRAME_LEN;
         IDX_LEFT:   cur_byte = cmd_ff.left_speed;
         IDX_PAD_L:  cur_byte = FRAME_PAD;
         IDX_RIGHT:  cur_byte = cmd_ff.right_speed;
         IDX_PAD_R:  cur_byte = FRAME_PAD;
         IDX_FLAG:   cur_byte = cmd_ff.flag;
         IDX_CRC_LO: cur_byte = crc_ff[BYTE_W-1:0];
         IDX_CRC_HI: cur_byte = crc_ff[CRC_W-1:BYTE_W];
         default:    cur_byte = FRAME_PAD;
      endcase
   end

   assign is_last     = (index_ff == IDX_CRC_HI);
   assign in_crc_span = (index_ff >= IDX_LEN) && (index_ff <= IDX_FLAG);
   assign take        = busy_ff && out_ready;
   assign cmd_ready   = !busy_ff || (out_ready && is_last);
   assign load        = cmd_valid && cmd_ready;

   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      cmd_in   = cmd_ff;
      crc_in   = crc_ff;
      if (load) begin
         busy_in  = 1'b1;
         index_in = IDX_SYNC;
         cmd_in   = cmd;
         crc_in   = CRC_INIT;
      end else if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            index_in = index_ff + 1'b1;
            if (in_crc_span) begin
               crc_in = crc16_byte(crc_ff, cur_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= IDX_SYNC;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
      cmd_ff <= cmd_in;
      crc_ff <= crc_in;
   end

   assign out_valid = busy_ff;
   assign out_byte  = cur_byte;
   assign out_last  = is_last;

endmodule

// ===== tb/dcfe_frame_checker.sv =====
// frame checker for the drive command frame encoder: predicts each motor frame and compares bytes
`timescale 1ns / 100ps
module dcfe_frame_checker
   import dcfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // direction_code [3:0], speed_percent [10:4], zero [15:11]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // frame_byte [7:0]
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          owed_bytes
);

   localparam int unsigned FULL_SCALE = 240;
   localparam int unsigned PERCENT    = 100;
   localparam int          FRAME_LEN_BYTES = 9;
   localparam int          REPORT_MAX = 10;

   typedef struct {
      logic [BYTE_W-1:0] frame_byte;
      logic              last_byte;
   } frame_beat_type;

   frame_beat_type due_bytes[$];
   int             miss_count;
   int             byte_count;

   initial begin
      mismatches = 0;
      owed_bytes = 0;
      miss_count = 0;
      byte_count = 0;
   end

   function automatic void steer(input  logic [CODE_W-1:0] code,
                                 output speed_kind_type    left_kind,
                                 output speed_kind_type    right_kind,
                                 output logic [BYTE_W-1:0] flag);
      case (code)
         DIR_UP:         begin left_kind = SPD_FULL; right_kind = SPD_FULL; flag = FLAG_FWD;  end
         DIR_DOWN:       begin left_kind = SPD_FULL; right_kind = SPD_FULL; flag = FLAG_REV;  end
         DIR_LEFT:       begin left_kind = SPD_ZERO; right_kind = SPD_FULL; flag = FLAG_FWD;  end
         DIR_RIGHT:      begin left_kind = SPD_FULL; right_kind = SPD_ZERO; flag = FLAG_FWD;  end
         DIR_LEFT_UP:    begin left_kind = SPD_RED;  right_kind = SPD_FULL; flag = FLAG_DIAG; end
         DIR_RIGHT_UP:   begin left_kind = SPD_FULL; right_kind = SPD_RED;  flag = FLAG_DIAG; end
         DIR_LEFT_DOWN:  begin left_kind = SPD_FULL; right_kind = SPD_FULL; flag = FLAG_NONE; end
         DIR_RIGHT_DOWN: begin left_kind = SPD_FULL; right_kind = SPD_RED;  flag = FLAG_NONE; end
         DIR_SPIN:       begin left_kind = SPD_RED;  right_kind = SPD_FULL; flag = FLAG_SPIN; end
         default:        begin left_kind = SPD_ZERO; right_kind = SPD_ZERO; flag = FLAG_NONE; end
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] wheel_speed(input speed_kind_type   kind,
                                                     input logic [PCT_W-1:0] pct);
      int unsigned full_speed;
      full_speed = (FULL_SCALE * pct) / PERCENT;
      case (kind)
         SPD_FULL: return full_speed[BYTE_W-1:0];
         SPD_RED:  return {1'b0, pct};
         default:  return '0;
      endcase
   endfunction

   // bit-serial reflected crc, lsb first
   function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0]  crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         fb = c[0] ^ data[i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void push_motor_frame(input logic [CODE_W-1:0] code,
                                            input logic [PCT_W-1:0]  pct_in);
      logic [PCT_W-1:0]  pct;
      speed_kind_type    left_kind;
      speed_kind_type    right_kind;
      logic [BYTE_W-1:0] flag;
      logic [BYTE_W-1:0] frame [FRAME_LEN_BYTES];
      logic [CRC_W-1:0]  crc;
      frame_beat_type    beat;
      pct = (pct_in > PCT_MAX) ? PCT_MAX : pct_in;
      steer(code, left_kind, right_kind, flag);
      frame[IDX_SYNC]  = FRAME_SYNC;
      frame[IDX_LEN]   = FRAME_LEN;
      frame[IDX_LEFT]  = wheel_speed(left_kind, pct);
      frame[IDX_PAD_L] = FRAME_PAD;
      frame[IDX_RIGHT] = wheel_speed(right_kind, pct);
      frame[IDX_PAD_R] = FRAME_PAD;
      frame[IDX_FLAG]  = flag;
      crc = CRC_INIT;
      for (int i = IDX_LEN; i <= IDX_FLAG; i++) begin
         crc = crc_update(crc, frame[i]);
      end
      frame[IDX_CRC_LO] = crc[BYTE_W-1:0];
      frame[IDX_CRC_HI] = crc[CRC_W-1:BYTE_W];
      for (int i = 0; i < FRAME_LEN_BYTES; i++) begin
         beat.frame_byte = frame[i];
         beat.last_byte  = (i == IDX_CRC_HI);
         due_bytes.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin : watch
      frame_beat_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            push_motor_frame(req_tdata[CODE_W-1:0], req_tdata[CODE_W+PCT_W-1:CODE_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            byte_count++;
            if (due_bytes.size() == 0) begin
               miss_count++;
               if (miss_count <= REPORT_MAX) begin
                  $display("unexpected frame byte #%0d: got %02h last %0b",
                           byte_count, rsp_tdata, rsp_tlast);
               end
            end else begin
               want = due_bytes.pop_front();
               if (rsp_tdata !== want.frame_byte || rsp_tlast !== want.last_byte) begin
                  miss_count++;
                  if (miss_count <= REPORT_MAX) begin
                     $display("frame byte #%0d: expected %02h last %0b, got %02h last %0b",
                              byte_count, want.frame_byte, want.last_byte,
                              rsp_tdata, rsp_tlast);
                  end
               end
            end
         end
      end
      mismatches <= miss_count;
      owed_bytes <= due_bytes.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the drive command frame encoder: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_top;
   import dcfe_pkg::*;

   localparam int CLOCK_HALF  = 5;
   localparam int RESET_LEN   = 4;
   localparam int RUN_LIMIT   = 200000;
   localparam int IDLE_PCT    = 31;
   localparam int HOLD_OFF    = 300;
   localparam int SETTLE      = 30;
   localparam logic [CODE_W-1:0] DIR_STOP = 4'd9;
   localparam logic [CODE_W-1:0] CODE_TOP = 4'hF;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // direction_code [3:0], speed_percent [10:4], zero [15:11]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // frame_byte [7:0]
   logic        rsp_tlast;

   logic        src_steady   = 1'b0;
   logic        sink_steady  = 1'b0;
   logic        hold_request = 1'b0;
   logic        hold_done    = 1'b0;
   int          hold_left    = 0;
   int          cycle_count  = 0;
   int          mismatches;
   int          owed_bytes;

   logic [PCT_W-1:0] corner_pct [4] = '{7'd0, 7'd127, 7'd100, 7'd101};

   always #CLOCK_HALF clock = ~clock;

   drive_command_frame_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   dcfe_frame_checker frame_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .owed_bytes (owed_bytes)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver side: random back-pressure, one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_OFF;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   function automatic logic [CODE_W-1:0] rand_code();
      logic [CODE_W-1:0] code;
      if ($urandom_range(0, 4) == 0) begin
         code = CODE_W'($urandom_range(DIR_STOP, CODE_TOP));
      end else begin
         code = CODE_W'($urandom_range(DIR_UP, DIR_SPIN));
      end
      return code;
   endfunction

   function automatic logic [PCT_W-1:0] rand_pct();
      logic [PCT_W-1:0] pct;
      case ($urandom_range(0, 9))
         0:       pct = PCT_MAX;
         1:       pct = '1;
         2:       pct = '0;
         default: pct = PCT_W'($urandom_range(0, 127));
      endcase
      return pct;
   endfunction

   task automatic send_command(input logic [CODE_W-1:0] code, input logic [PCT_W-1:0] pct);
      if (!src_steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, pct, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // every code with the speed corners, then a few extra speed corners
      for (int c = DIR_UP; c <= CODE_TOP; c++) begin
         send_command(c[CODE_W-1:0], corner_pct[c % 4]);
      end
      send_command(DIR_SPIN, 7'd127);
      send_command(DIR_LEFT_UP, 7'd101);
      send_command(DIR_RIGHT_DOWN, 7'd1);
      send_command(DIR_UP, 7'd99);

      // fill the block while the receiver holds off
      hold_request <= 1'b1;
      src_steady = 1'b1;
      repeat (16) send_command(rand_code(), rand_pct());
      src_steady = 1'b0;
      repeat (34) send_command(rand_code(), rand_pct());

      src_steady = 1'b1;
      sink_steady <= 1'b1;
      repeat (30) send_command(rand_code(), rand_pct());
      src_steady = 1'b0;
      sink_steady <= 1'b0;
      repeat (20) send_command(rand_code(), rand_pct());
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (owed_bytes != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && owed_bytes == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
